>>> rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SCPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define SCPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/scpa_pkg.sv
package scpa_pkg;

  localparam int BYTES_W     = 16;
  localparam int COUNT_W     = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_CLASSES = 4;
  localparam int CFG_BYTES_BASE = 0;
  localparam int CFG_COUNT_BASE = 4;
  localparam int PORT_CLASS_W = 2;
  localparam int PORT_SLOT_W  = 5;

  localparam logic [BYTES_W-1:0] BYTES_AT_RESET [8] = '{
    16'd128, 16'd256, 16'd512, 16'd1024, 16'd1024, 16'd1024, 16'd1024, 16'd1024
  };
  localparam logic [COUNT_W-1:0] COUNT_AT_RESET [8] = '{
    6'd10, 6'd5, 6'd20, 6'd8, 6'd0, 6'd0, 6'd0, 6'd0
  };

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_FREE   = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  // Operands of the shared compare unit.
  typedef struct packed {
    logic [BYTES_W-1:0] a;
    logic [BYTES_W-1:0] b;
  } cmp_req_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_rsp_t;

endpackage

>>> rtl/scpa_cmp_unit.sv
module scpa_cmp_unit import scpa_pkg::*; (
  input  cmp_req_t req_i,
  output cmp_rsp_t rsp_o
);

  logic [BYTES_W:0] diff;

  // Borrow out of a - b means a < b.
  assign diff      = {1'b0, req_i.a} - {1'b0, req_i.b};
  assign rsp_o.lt  = diff[BYTES_W];
  assign rsp_o.eq  = (diff[BYTES_W-1:0] == '0);

endmodule

>>> rtl/scpa_ctrl.sv
module scpa_ctrl import scpa_pkg::*; #(
  parameter int MAX_BLOCKS_PER_CLASS = 32,
  parameter int NUM_CLASSES          = 4,
  localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1,
  localparam int SLOT_W = (MAX_BLOCKS_PER_CLASS > 1) ? $clog2(MAX_BLOCKS_PER_CLASS) : 1,
  localparam int CNT_W  = $clog2(MAX_BLOCKS_PER_CLASS + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     cmd_i,
  input  logic [BYTES_W-1:0]       request_bytes_i,
  input  logic [PORT_CLASS_W-1:0]  release_class_i,
  input  logic [PORT_SLOT_W-1:0]   release_slot_i,
  input  logic [BYTES_W-1:0]       class_bytes_i [NUM_CLASSES],
  input  logic [CNT_W-1:0]         usable_i [NUM_CLASSES],
  output logic                     done_o,
  output logic [1:0]               status_o,
  output logic [PORT_CLASS_W-1:0]  granted_class_o,
  output logic [PORT_SLOT_W-1:0]   granted_slot_o
);

`include "assert_macros.svh"

  localparam logic [CLS_W-1:0] TOP_CLS = CLS_W'(NUM_CLASSES - 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LIMIT = 6'b000010,
    S_CLASS = 6'b000100,
    S_SCAN  = 6'b001000,
    S_FREE  = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic                    cmd_q;
  logic [BYTES_W-1:0]      size_q;
  logic [PORT_CLASS_W-1:0] rc_q;
  logic [PORT_SLOT_W-1:0]  rs_q;
  logic [CLS_W-1:0]        cls_q, cls_d;
  logic [CNT_W-1:0]        slot_q, slot_d;
  status_e                 status_q, status_d;
  logic [PORT_CLASS_W-1:0] gcls_q, gcls_d;
  logic [PORT_SLOT_W-1:0]  gslot_q, gslot_d;

  logic [MAX_BLOCKS_PER_CLASS-1:0] flags_q [NUM_CLASSES];

  logic             flag_set, flag_clr;
  logic [CLS_W-1:0] flag_cls;
  logic [SLOT_W-1:0] flag_slot;

  logic             rc_ok;
  logic [CLS_W-1:0] rc_idx;
  logic [SLOT_W-1:0] rs_idx;

  cmp_req_t cmp_req;
  cmp_rsp_t cmp_rsp;

  scpa_cmp_unit u_cmp (
    .req_i (cmp_req),
    .rsp_o (cmp_rsp)
  );

  assign rc_ok  = (32'(rc_q) < NUM_CLASSES);
  assign rc_idx = rc_ok ? CLS_W'(rc_q) : '0;
  assign rs_idx = SLOT_W'(rs_q);

  // Steer the shared compare unit by state.
  always_comb begin
    cmp_req.a = size_q;
    cmp_req.b = class_bytes_i[TOP_CLS];
    unique case (state_q)
      S_CLASS: begin
        cmp_req.b = class_bytes_i[cls_q];
      end
      S_SCAN: begin
        cmp_req.a = BYTES_W'(slot_q);
        cmp_req.b = BYTES_W'(usable_i[cls_q]);
      end
      S_FREE: begin
        cmp_req.a = BYTES_W'(rs_q);
        cmp_req.b = BYTES_W'(usable_i[rc_idx]);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    cls_d     = cls_q;
    slot_d    = slot_q;
    status_d  = status_q;
    gcls_d    = gcls_q;
    gslot_d   = gslot_q;
    flag_set  = 1'b0;
    flag_clr  = 1'b0;
    flag_cls  = cls_q;
    flag_slot = slot_q[SLOT_W-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          status_d = ST_OK;
          gcls_d   = '0;
          gslot_d  = '0;
          cls_d    = '0;
          slot_d   = '0;
          state_d  = (cmd_i == CMD_FREE) ? S_FREE : S_LIMIT;
        end
      end
      S_LIMIT: begin
        // Reject anything above the top class size.
        if (!(cmp_rsp.lt || cmp_rsp.eq)) begin
          status_d = ST_TOO_LARGE;
          state_d  = S_DONE;
        end else begin
          state_d = S_CLASS;
        end
      end
      S_CLASS: begin
        if (cmp_rsp.lt || cmp_rsp.eq || cls_q == TOP_CLS) begin
          state_d = S_SCAN;
        end else begin
          cls_d = cls_q + 1'b1;
        end
      end
      S_SCAN: begin
        if (!cmp_rsp.lt) begin
          status_d = ST_NO_FREE;
          state_d  = S_DONE;
        end else if (!flags_q[cls_q][slot_q[SLOT_W-1:0]]) begin
          flag_set = 1'b1;
          gcls_d   = PORT_CLASS_W'(cls_q);
          gslot_d  = PORT_SLOT_W'(slot_q);
          state_d  = S_DONE;
        end else begin
          slot_d = slot_q + 1'b1;
        end
      end
      S_FREE: begin
        flag_cls  = rc_idx;
        flag_slot = rs_idx;
        if (!rc_ok || !cmp_rsp.lt || !flags_q[rc_idx][rs_idx]) begin
          status_d = ST_BAD_FREE;
        end else begin
          flag_clr = 1'b1;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        flags_q[c] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (flag_set) begin
        flags_q[flag_cls][flag_slot] <= 1'b1;
      end
      if (flag_clr) begin
        flags_q[flag_cls][flag_slot] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      cmd_q  <= cmd_i;
      size_q <= request_bytes_i;
      rc_q   <= release_class_i;
      rs_q   <= release_slot_i;
    end
    cls_q    <= cls_d;
    slot_q   <= slot_d;
    status_q <= status_d;
    gcls_q   <= gcls_d;
    gslot_q  <= gslot_d;
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = (state_q == S_DONE);
  assign status_o        = status_q;
  assign granted_class_o = gcls_q;
  assign granted_slot_o  = gslot_q;

  `SCPA_ASSERT_NEXT(a_done_pulse, done_o, !done_o, "done held for more than one cycle")
  `SCPA_ASSERT_NEXT(a_start_busy, start && !busy, busy, "request taken but block not busy")
  `SCPA_ASSERT(a_grant_flag,
    !(done_o && status_q == ST_OK && cmd_q == CMD_ALLOC) || flags_q[cls_q][slot_q[SLOT_W-1:0]],
    "granted block not marked allocated")
  `SCPA_ASSERT(a_fail_zero,
    !(done_o && status_q != ST_OK) || (gcls_q == '0 && gslot_q == '0),
    "failed request carries a nonzero handle")

endmodule

>>> rtl/size_class_block_pool_allocator.sv
// Channel   | Signals                                              | Handshake
// ----------|------------------------------------------------------|-------------------------
// request   | cmd_i, request_bytes_i, release_class_i, release_slot_i | start && !busy
// result    | status_o, granted_class_o, granted_slot_o            | done_o, one cycle
// config    | cfg_idx_i, cfg_wdata_i                               | cfg_we_i
//
// Free or oversize allocate: S_FREE or S_LIMIT, then S_DONE with done_o.
// Allocate: S_LIMIT, k class compares (1..NUM_CLASSES) and s slot probes
// (1..usable count + 1), all through the one shared comparator, then S_DONE.
// busy covers the done_o cycle too; the next request is taken in the cycle after.
// done_o is never stalled, the receiver must take it in that cycle.
// Reset clears every allocated flag and loads the default class sizes/counts.
module size_class_block_pool_allocator import scpa_pkg::*; #(
  parameter int MAX_BLOCKS_PER_CLASS = 32,
  parameter int NUM_CLASSES          = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    cmd_i,
  input  logic [BYTES_W-1:0]      request_bytes_i,
  input  logic [PORT_CLASS_W-1:0] release_class_i,
  input  logic [PORT_SLOT_W-1:0]  release_slot_i,
  output logic                    done_o,
  output logic [1:0]              status_o,
  output logic [PORT_CLASS_W-1:0] granted_class_o,
  output logic [PORT_SLOT_W-1:0]  granted_slot_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [BYTES_W-1:0]      cfg_wdata_i
);

  localparam int CNT_W = $clog2(MAX_BLOCKS_PER_CLASS + 1);

  // Class size and count registers; only the first four classes are writable.
  logic [BYTES_W-1:0] class_bytes_q [NUM_CLASSES];
  logic [COUNT_W-1:0] class_count_q [NUM_CLASSES];
  logic [CNT_W-1:0]   usable        [NUM_CLASSES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        class_bytes_q[c] <= BYTES_AT_RESET[c];
        class_count_q[c] <= COUNT_AT_RESET[c];
      end
    end else if (cfg_we_i) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        if (c < CFG_CLASSES && 32'(cfg_idx_i) == CFG_BYTES_BASE + c) begin
          class_bytes_q[c] <= cfg_wdata_i;
        end
        if (c < CFG_CLASSES && 32'(cfg_idx_i) == CFG_COUNT_BASE + c) begin
          class_count_q[c] <= cfg_wdata_i[COUNT_W-1:0];
        end
      end
    end
  end

  // Clamp each count to the slots that physically exist.
  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if ({1'b0, class_count_q[c]} > (COUNT_W+1)'(MAX_BLOCKS_PER_CLASS)) begin
        usable[c] = CNT_W'(MAX_BLOCKS_PER_CLASS);
      end else begin
        usable[c] = CNT_W'(class_count_q[c]);
      end
    end
  end

  // Sequence each request through the shared comparator.
  scpa_ctrl #(
    .MAX_BLOCKS_PER_CLASS (MAX_BLOCKS_PER_CLASS),
    .NUM_CLASSES          (NUM_CLASSES)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .cmd_i           (cmd_i),
    .request_bytes_i (request_bytes_i),
    .release_class_i (release_class_i),
    .release_slot_i  (release_slot_i),
    .class_bytes_i   (class_bytes_q),
    .usable_i        (usable),
    .done_o          (done_o),
    .status_o        (status_o),
    .granted_class_o (granted_class_o),
    .granted_slot_o  (granted_slot_o)
  );

endmodule

>>> tb/sv/tb_size_class_block_pool_allocator.sv
`timescale 1ns / 100ps

module tb_size_class_block_pool_allocator;
  import scpa_pkg::*;

  localparam int SLOTS   = 32;
  localparam int CLASSES = 4;
  localparam int PHASES  = 6;
  localparam int PHASE_REQUESTS = 100;
  // Longest allocate: four class compares, a full slot scan, the limit and done states.
  localparam int TAIL_CYCLES = 45;

  // One request as the sender sees it; unused fields still carry values.
  typedef struct packed {
    cmd_e                    cmd;
    logic [BYTES_W-1:0]      bytes;
    logic [PORT_CLASS_W-1:0] rclass;
    logic [PORT_SLOT_W-1:0]  rslot;
  } pool_req_t;

  // One result of the block.
  typedef struct packed {
    status_e                 status;
    logic [PORT_CLASS_W-1:0] gclass;
    logic [PORT_SLOT_W-1:0]  gslot;
  } grant_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  // A row of the directed walk: either a request or a register write.
  typedef struct {
    row_kind_e          kind;
    pool_req_t          rq;
    logic               pinned;
    grant_t             want;
    logic [CFG_IDX_W-1:0] idx;
    logic [BYTES_W-1:0] data;
  } walk_row_t;

  logic                    clk_i;
  logic                    rst_ni          = 1'b0;
  logic                    start           = 1'b0;
  logic                    busy;
  logic                    cmd_i           = CMD_ALLOC;
  logic [BYTES_W-1:0]      request_bytes_i = '0;
  logic [PORT_CLASS_W-1:0] release_class_i = '0;
  logic [PORT_SLOT_W-1:0]  release_slot_i  = '0;
  logic                    done_o;
  logic [1:0]              status_o;
  logic [PORT_CLASS_W-1:0] granted_class_o;
  logic [PORT_SLOT_W-1:0]  granted_slot_o;
  logic                    cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i       = '0;
  logic [BYTES_W-1:0]      cfg_wdata_i     = '0;

  // Predictor copy of the pool: class sizes, counts and the held-block map.
  logic [BYTES_W-1:0] pool_bytes [CLASSES] = '{16'd128, 16'd256, 16'd512, 16'd1024};
  logic [COUNT_W-1:0] pool_count [CLASSES] = '{6'd10, 6'd5, 6'd20, 6'd8};
  logic [SLOTS-1:0]   held_map   [CLASSES] = '{default: '0};

  grant_t    grant_q [$];
  grant_t    oldest_grant;
  walk_row_t directed_rows [$];
  int        mismatches = 0;

  size_class_block_pool_allocator u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .cmd_i           (cmd_i),
    .request_bytes_i (request_bytes_i),
    .release_class_i (release_class_i),
    .release_slot_i  (release_slot_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .granted_class_o (granted_class_o),
    .granted_slot_o  (granted_slot_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Compute the grant for one request and advance the held-block map.
  function automatic grant_t predict_grant(input pool_req_t rq);
    grant_t           g;
    int               cls;
    int               usable;
    logic [SLOTS:0]   span;
    logic [SLOTS-1:0] avail;
    g.status = ST_OK;
    g.gclass = '0;
    g.gslot  = '0;
    if (rq.cmd == CMD_ALLOC) begin
      if (rq.bytes > pool_bytes[CLASSES-1]) begin
        g.status = ST_TOO_LARGE;
      end else begin
        // Take the lowest-numbered class that covers the size; never fall through.
        cls = CLASSES - 1;
        for (int k = CLASSES - 1; k >= 0; k--) begin
          if (rq.bytes <= pool_bytes[k]) cls = k;
        end
        usable = (pool_count[cls] > SLOTS) ? SLOTS : pool_count[cls];
        span   = ({{SLOTS{1'b0}}, 1'b1} << usable) - 1'b1;
        avail  = ~held_map[cls] & span[SLOTS-1:0];
        if (avail == '0) begin
          g.status = ST_NO_FREE;
        end else begin
          for (int s = SLOTS - 1; s >= 0; s--) begin
            if (avail[s]) g.gslot = s;
          end
          held_map[cls][g.gslot] = 1'b1;
          g.gclass = cls;
        end
      end
    end else begin
      // Slots at or above the current count are out of reach, held or not.
      usable = (pool_count[rq.rclass] > SLOTS) ? SLOTS : pool_count[rq.rclass];
      if (rq.rslot >= usable || !held_map[rq.rclass][rq.rslot]) begin
        g.status = ST_BAD_FREE;
      end else begin
        held_map[rq.rclass][rq.rslot] = 1'b0;
      end
    end
    return g;
  endfunction

  // Build a random request: mostly allocates sized to hit a class and frees of
  // blocks really held, with some oversize, zero and bogus-handle noise.
  function automatic pool_req_t random_request();
    pool_req_t rq;
    int        roll;
    int        sub;
    int        k;
    int        c0;
    int        s0;
    int        cc;
    int        ss;
    logic      found;
    rq.cmd    = CMD_ALLOC;
    rq.bytes  = $urandom;
    rq.rclass = $urandom;
    rq.rslot  = $urandom;
    roll = $urandom_range(99);
    found = 1'b0;
    if (roll < 50) begin
      k   = $urandom_range(CLASSES - 1);
      sub = $urandom_range(99);
      if (sub < 60) begin
        rq.bytes = $urandom_range(pool_bytes[k]);
      end else if (sub < 72) begin
        rq.bytes = pool_bytes[k];
      end else if (sub < 77) begin
        rq.bytes = '0;
      end else if (sub < 88 && pool_bytes[CLASSES-1] != '1) begin
        rq.bytes = $urandom_range(16'hFFFF, pool_bytes[CLASSES-1] + 1);
      end
    end else if (roll < 85) begin
      rq.cmd = CMD_FREE;
      c0 = $urandom_range(CLASSES - 1);
      s0 = $urandom_range(SLOTS - 1);
      for (cc = 0; cc < CLASSES && !found; cc++) begin
        for (ss = 0; ss < SLOTS && !found; ss++) begin
          if (held_map[(c0 + cc) % CLASSES][(s0 + ss) % SLOTS]) begin
            rq.rclass = (c0 + cc) % CLASSES;
            rq.rslot  = (s0 + ss) % SLOTS;
            found = 1'b1;
          end
        end
      end
    end else begin
      rq.cmd = CMD_FREE;
    end
    return rq;
  endfunction

  // Hold start low for a random number of cycles.
  task automatic idle_gap(input int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Present one request and hold it until the block takes it. Returns at the
  // accepting edge so the caller can keep start high for the next request.
  task automatic send_request(input pool_req_t rq, input logic pinned, input grant_t want);
    grant_t g;
    start           <= 1'b1;
    cmd_i           <= rq.cmd;
    request_bytes_i <= rq.bytes;
    release_class_i <= rq.rclass;
    release_slot_i  <= rq.rslot;
    do @(posedge clk_i); while (busy !== 1'b0);
    g = predict_grant(rq);
    grant_q.push_back(pinned ? want : g);
  endtask

  // Wait out every pending result so that the block is idle.
  task automatic drain();
    while (grant_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Write one register and mirror it in the predictor.
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTES_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    if (idx < CFG_COUNT_BASE) pool_bytes[idx] = data;
    else pool_count[idx - CFG_COUNT_BASE] = data[COUNT_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic void req_row(input cmd_e cmd, input int bytes, input int rc, input int rs,
                                  input logic pinned, input status_e st, input int gc,
                                  input int gs);
    walk_row_t r;
    r.kind        = ROW_REQ;
    r.rq.cmd      = cmd;
    r.rq.bytes    = bytes;
    r.rq.rclass   = rc;
    r.rq.rslot    = rs;
    r.pinned      = pinned;
    r.want.status = st;
    r.want.gclass = gc;
    r.want.gslot  = gs;
    r.idx         = '0;
    r.data        = '0;
    directed_rows.push_back(r);
  endfunction

  function automatic void cfg_row(input int idx, input int data);
    walk_row_t r;
    r.kind = ROW_CFG;
    r.rq   = '0;
    r.pinned = 1'b0;
    r.want = '0;
    r.idx  = idx;
    r.data = data;
    directed_rows.push_back(r);
  endfunction

  // Check each result against the oldest pending grant, field by field.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (grant_q.size() == 0) begin
        report_mismatch($sformatf("result with no request pending, status %0d", status_o));
      end else begin
        oldest_grant = grant_q.pop_front();
        if (status_o !== oldest_grant.status)
          report_mismatch($sformatf("status got %0d want %0d", status_o, oldest_grant.status));
        if (granted_class_o !== oldest_grant.gclass)
          report_mismatch($sformatf("granted_class got %0d want %0d",
                                    granted_class_o, oldest_grant.gclass));
        if (granted_slot_o !== oldest_grant.gslot)
          report_mismatch($sformatf("granted_slot got %0d want %0d",
                                    granted_slot_o, oldest_grant.gslot));
      end
    end
  end

  initial begin
    logic [BYTES_W-1:0] setting_regs [PHASES][8];
    logic [BYTES_W-1:0] data;
    int                 pct;
    grant_t             no_grant;

    no_grant = '0;
    // Size and count settings per random phase: tiny sizes with full classes,
    // all-max sizes with saturating counts, unordered sizes with counts lowered
    // under held blocks, empty classes, random, and back to the defaults.
    setting_regs = '{
      '{16'd1,     16'd2,     16'd3,     16'd65535, 16'd32, 16'd32, 16'd32, 16'd32},
      '{16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd63, 16'd40, 16'd33, 16'd32},
      '{16'd1000,  16'd50,    16'd65535, 16'd300,   16'd4,  16'd3,  16'd2,  16'd6},
      '{16'd16,    16'd64,    16'd256,   16'd4096,  16'd0,  16'd1,  16'd0,  16'd2},
      '{16'd0,     16'd0,     16'd0,     16'd0,     16'd0,  16'd0,  16'd0,  16'd0},
      '{16'd128,   16'd256,   16'd512,   16'd1024,  16'd10, 16'd5,  16'd20, 16'd8}
    };

    // Directed walk under the reset settings 128/256/512/1024 and 10/5/20/8.
    req_row(CMD_ALLOC, 0,     0, 0,  1'b1, ST_OK,        0, 0);
    req_row(CMD_ALLOC, 128,   0, 0,  1'b1, ST_OK,        0, 1);
    req_row(CMD_ALLOC, 129,   0, 0,  1'b1, ST_OK,        1, 0);
    req_row(CMD_ALLOC, 1024,  3, 31, 1'b1, ST_OK,        3, 0);
    req_row(CMD_ALLOC, 1025,  0, 0,  1'b1, ST_TOO_LARGE, 0, 0);
    req_row(CMD_ALLOC, 65535, 3, 31, 1'b1, ST_TOO_LARGE, 0, 0);
    req_row(CMD_FREE,  65535, 0, 0,  1'b1, ST_OK,        0, 0);
    req_row(CMD_FREE,  0,     0, 0,  1'b1, ST_BAD_FREE,  0, 0);
    req_row(CMD_FREE,  0,     2, 31, 1'b1, ST_BAD_FREE,  0, 0);
    req_row(CMD_FREE,  0,     1, 5,  1'b1, ST_BAD_FREE,  0, 0);
    // Fill class one, then ask once more: it must not spill into class two.
    req_row(CMD_ALLOC, 200,   0, 0,  1'b0, ST_OK, 0, 0);
    req_row(CMD_ALLOC, 256,   0, 0,  1'b0, ST_OK, 0, 0);
    req_row(CMD_ALLOC, 256,   0, 0,  1'b0, ST_OK, 0, 0);
    req_row(CMD_ALLOC, 256,   0, 0,  1'b0, ST_OK, 0, 0);
    req_row(CMD_ALLOC, 255,   0, 0,  1'b0, ST_OK, 0, 0);
    // Shrink class one below held slots; those slots become unreachable.
    cfg_row(CFG_COUNT_BASE + 1, 2);
    req_row(CMD_FREE,  0,     1, 3,  1'b0, ST_OK, 0, 0);
    req_row(CMD_FREE,  0,     1, 1,  1'b0, ST_OK, 0, 0);
    req_row(CMD_ALLOC, 1,     0, 0,  1'b0, ST_OK, 0, 0);
    // Unordered sizes: class zero now covers more than class one.
    cfg_row(CFG_BYTES_BASE + 0, 600);
    req_row(CMD_ALLOC, 300,   0, 0,  1'b0, ST_OK, 0, 0);
    // Empty top class, and a count written above capacity with junk bits.
    cfg_row(CFG_COUNT_BASE + 3, 0);
    req_row(CMD_ALLOC, 1000,  0, 0,  1'b0, ST_OK, 0, 0);
    cfg_row(CFG_COUNT_BASE + 2, 16'hFFFF);
    req_row(CMD_ALLOC, 512,   0, 0,  1'b0, ST_OK, 0, 0);
    cfg_row(CFG_BYTES_BASE + 3, 65535);
    req_row(CMD_ALLOC, 65535, 0, 0,  1'b0, ST_OK, 0, 0);

    // Hold reset, then release it on a clock edge.
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        // Registers change only with the block idle.
        start <= 1'b0;
        drain();
        write_cfg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        idle_gap(11);
        send_request(directed_rows[i].rq, directed_rows[i].pinned, directed_rows[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      start <= 1'b0;
      drain();
      for (int r = 0; r < 8; r++) begin
        data = setting_regs[p][r];
        if (p == 4) begin
          data = (r < CFG_COUNT_BASE) ? $urandom_range(16'hFFFF, 1) : $urandom_range(40);
        end
        // Fill the unused upper bits of count writes; the block must drop them.
        if (r >= CFG_COUNT_BASE) data[BYTES_W-1:COUNT_W] = $urandom;
        write_cfg(r, data);
      end
      // Sender idles lightly, then heavily, then not at all.
      pct = (p < 2) ? 11 : (p < 4) ? 88 : 0;
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        idle_gap(pct);
        send_request(random_request(), 1'b0, no_grant);
      end
    end

    start <= 1'b0;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && grant_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/scpa_pkg.sv
rtl/scpa_cmp_unit.sv
rtl/scpa_ctrl.sv
rtl/size_class_block_pool_allocator.sv
tb/sv/tb_size_class_block_pool_allocator.sv
